FILE: rtl/core/mfr_pkg.sv
// ============================================================================
// mfr_pkg
// Shared types and constants of the multidrop frame receiver.
// ============================================================================
package mfr_pkg;

    // Default depth of the command store
    localparam int CMD_DEPTH_DEF = 32;

    // Byte codes
    localparam logic [7:0] LINE_FEED = 8'h0A;
    localparam logic [7:0] SUM_MASK  = 8'h7F;
    localparam logic [7:0] REPLY_OK  = 8'h80;
    localparam logic [7:0] REPLY_BAD = 8'h81;

    // Result kinds (master tuser)
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_CMD   = 1'b1;

    // Configuration register byte addresses
    localparam logic [1:0] ADDR_MY_ADDRESS = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DATA,
        ST_CHECK,
        ST_READ,
        ST_EVAL,
        ST_FLUSH
    } fsm_state_t;

endpackage

FILE: rtl/core/mfr_cmd_ram.sv
// ============================================================================
// mfr_cmd_ram
// Command byte store: one write port, one read port, registered read data.
// ============================================================================
module mfr_cmd_ram #(
    parameter int CMD_DEPTH = mfr_pkg::CMD_DEPTH_DEF,
    parameter int AW        = $clog2(CMD_DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [CMD_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/multidrop_frame_receiver_core.sv
// ============================================================================
// multidrop_frame_receiver_core
// Addressed frame receiver for a 9-bit multidrop serial bus, with checksum
// test and reply / command byte delivery.
// ============================================================================
//
//  Channel   Direction  Contents
//  --------  ---------  ----------------------------------------------------
//  s_axis    in         tdata = rx_byte, tuser = ninth_bit
//  m_axis    out        tdata = out_byte, tuser = out_kind, tlast = last
//  apb       in         register 0 (byte address 0): my_address
//
//  Address and data bytes are accepted whenever offered; s_tready stays high
//  in those states. A check byte is taken only when the output register is
//  free. A match then reads the command store one byte at a time, through the
//  states ST_READ (address) and ST_EVAL (registered memory data), as the
//  store has a single read port; no new byte is taken until the last item is
//  loaded. Output stalls hold the sequencer; reset returns to idle, the store
//  is not cleared.
//
module multidrop_frame_receiver_core #(
    parameter int CMD_DEPTH = mfr_pkg::CMD_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] ninth_bit

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tuser,   // [0] out_kind
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    mfr_pkg::fsm_state_t state_reg, state_next;

    logic [7:0]    my_address_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    sum_reg, sum_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_kind_reg, pend_kind_next;
    logic [7:0]    pend_byte_reg, pend_byte_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_tdata_reg;
    logic          m_tuser_reg;
    logic          m_tlast_reg;

    logic          out_free;
    logic          out_load;
    logic          out_kind;
    logic [7:0]    out_byte;
    logic          out_last;

    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr == mfr_pkg::ADDR_MY_ADDRESS) ? {24'd0, my_address_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_address_reg <= 8'd0;
        end
        else if (psel && penable && pwrite && pready
                 && paddr == mfr_pkg::ADDR_MY_ADDRESS)
        begin
            my_address_reg <= pwdata[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Command store
    // ------------------------------------------------------------------
    mfr_cmd_ram #(
        .CMD_DEPTH (CMD_DEPTH),
        .AW        (AW)
    ) u_cmd_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfr_pkg::ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= 8'd0;
            rd_idx_reg    <= '0;
            pend_kind_reg <= mfr_pkg::KIND_REPLY;
            pend_byte_reg <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            rd_idx_reg    <= rd_idx_next;
            pend_kind_reg <= pend_kind_next;
            pend_byte_reg <= pend_byte_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        rd_idx_next    = rd_idx_reg;
        pend_kind_next = pend_kind_reg;
        pend_byte_next = pend_byte_reg;
        s_tready       = 1'b0;
        out_load       = 1'b0;
        out_kind       = pend_kind_reg;
        out_byte       = pend_byte_reg;
        out_last       = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (state_reg)
            mfr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && s_tready && s_tuser && s_tdata == my_address_reg)
                begin
                    state_next = mfr_pkg::ST_DATA;
                    count_next = '0;
                    sum_next   = my_address_reg;
                end
            end

            mfr_pkg::ST_DATA:
            begin
                s_tready = 1'b1;
                if (s_tvalid && s_tready)
                begin
                    // Keep summing once the store is full
                    if (count_reg < CW'(CMD_DEPTH))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    sum_next = sum_reg + s_tdata;
                    if (s_tdata == mfr_pkg::LINE_FEED)
                    begin
                        state_next = mfr_pkg::ST_CHECK;
                    end
                end
            end

            mfr_pkg::ST_CHECK:
            begin
                s_tready = out_free;
                if (s_tvalid && s_tready)
                begin
                    if (s_tdata == (sum_reg & mfr_pkg::SUM_MASK))
                    begin
                        if (count_reg == '0)
                        begin
                            out_load   = 1'b1;
                            out_kind   = mfr_pkg::KIND_REPLY;
                            out_byte   = mfr_pkg::REPLY_OK;
                            out_last   = 1'b1;
                            state_next = mfr_pkg::ST_IDLE;
                        end
                        else
                        begin
                            pend_kind_next = mfr_pkg::KIND_REPLY;
                            pend_byte_next = mfr_pkg::REPLY_OK;
                            rd_idx_next    = '0;
                            state_next     = mfr_pkg::ST_READ;
                        end
                    end
                    else
                    begin
                        out_load   = 1'b1;
                        out_kind   = mfr_pkg::KIND_REPLY;
                        out_byte   = mfr_pkg::REPLY_BAD;
                        out_last   = 1'b1;
                        state_next = mfr_pkg::ST_IDLE;
                    end
                end
            end

            mfr_pkg::ST_READ:
            begin
                if (rd_idx_reg == count_reg)
                begin
                    state_next = mfr_pkg::ST_FLUSH;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = mfr_pkg::ST_EVAL;
                end
            end

            mfr_pkg::ST_EVAL:
            begin
                // Pending item is last if the fetched byte is zero
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (ram_rdata == 8'd0)
                    begin
                        out_last   = 1'b1;
                        state_next = mfr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pend_kind_next = mfr_pkg::KIND_CMD;
                        pend_byte_next = ram_rdata;
                        rd_idx_next    = rd_idx_reg + CW'(1);
                        state_next     = mfr_pkg::ST_READ;
                    end
                end
            end

            mfr_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    state_next = mfr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mfr_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= out_byte;
            m_tuser_reg <= out_kind;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: rtl/core/mfr_checker.sv
// ============================================================================
// mfr_checker
// Port-level checks of the multidrop frame receiver result stream.
// ============================================================================
module mfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // Hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_reply_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == mfr_pkg::KIND_REPLY |->
            m_tdata == mfr_pkg::REPLY_OK || m_tdata == mfr_pkg::REPLY_BAD)
        else $error("reply item carries an unknown code");

    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == mfr_pkg::KIND_REPLY && m_tdata == mfr_pkg::REPLY_BAD
            |-> m_tlast)
        else $error("checksum failure reply not marked last");

    a_cmd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == mfr_pkg::KIND_CMD |-> m_tdata != 8'd0)
        else $error("zero byte delivered as command");

endmodule

bind multidrop_frame_receiver_core mfr_checker u_mfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: tb/sv/multidrop_frame_receiver_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// multidrop_frame_receiver_core_tb
// Self-checking testbench for the multidrop frame receiver core.
// Builds addressed frames and noise on the byte stream and predicts every
// reply and command byte. Checks each output item in order against the
// prediction. Both sides idle at random, and the output side holds off once
// for a long stretch.
// ============================================================================
module multidrop_frame_receiver_core_tb;

    localparam int CMD_DEPTH    = mfr_pkg::CMD_DEPTH_DEF;
    localparam int TAIL_CYCLES  = 2 * CMD_DEPTH + 40;
    localparam int RANDOM_ITEMS = 130;
    localparam int LONG_HOLD    = 500;

    typedef enum logic [1:0] {
        WAIT_ADDR,
        TAKE_DATA,
        TAKE_CHECK
    } frame_phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } out_item_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [1:0]  paddr    = 2'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted receiver state
    frame_phase_t fr_phase = WAIT_ADDR;
    logic [7:0]   fr_store [CMD_DEPTH];
    int           fr_count = 0;
    logic [7:0]   fr_sum   = 8'h00;
    logic [7:0]   station_addr = 8'h00;

    out_item_t    pending_out [$];
    logic [7:0]   frame_body [$];

    int mismatches  = 0;
    int results_in  = 0;
    int items_sent  = 0;
    bit src_gaps    = 1'b0;
    bit sink_gaps   = 1'b0;
    int out_gap     = 0;
    int hold_req    = 0;
    int hold_left   = 0;

    multidrop_frame_receiver_core #(
        .CMD_DEPTH(CMD_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Advance the predicted receiver by one accepted item
    task automatic predict_replies(input logic [7:0] c, input logic nb);
        int len;
        case (fr_phase)
            TAKE_DATA:
            begin
                if (fr_count < CMD_DEPTH)
                begin
                    fr_store[fr_count] = c;
                    fr_count++;
                end
                fr_sum = fr_sum + c;
                if (c == mfr_pkg::LINE_FEED)
                    fr_phase = TAKE_CHECK;
            end
            TAKE_CHECK:
            begin
                if (c == (fr_sum & mfr_pkg::SUM_MASK))
                begin
                    len = 0;
                    while (len < fr_count && fr_store[len] != 8'h00)
                        len++;
                    pending_out.push_back('{mfr_pkg::KIND_REPLY, mfr_pkg::REPLY_OK,
                                            len == 0});
                    for (int i = 0; i < len; i++)
                        pending_out.push_back('{mfr_pkg::KIND_CMD, fr_store[i],
                                                i == len - 1});
                end
                else
                begin
                    pending_out.push_back('{mfr_pkg::KIND_REPLY, mfr_pkg::REPLY_BAD, 1'b1});
                end
                fr_phase = WAIT_ADDR;
            end
            default:
            begin
                if (nb && c == station_addr)
                begin
                    fr_phase = TAKE_DATA;
                    fr_count = 0;
                    fr_sum   = station_addr;
                end
            end
        endcase
    endtask

    // Output side: sample at the rising edge and compare with the oldest prediction
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata, m_tlast};
            if (pending_out.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item kind %0b byte %02h last %0b",
                                          got.kind, got.data, got.last));
            end
            else
            begin
                want = pending_out.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.last !== want.last)
                    report_mismatch($sformatf(
                        "item %0d: kind %0b byte %02h last %0b, want %0b %02h %0b",
                        results_in, got.kind, got.data, got.last,
                        want.kind, want.data, want.last));
            end
            results_in++;
            out_gap = sink_gaps ? $urandom_range(0, 7) : 0;
        end
    end

    // Output side ready: long hold first, then the per-item gap
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [7:0] b, input logic nb);
        int gap;
        gap = src_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= b;
        s_tuser  <= nb;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_replies(b, nb);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_results_done;
        s_tvalid <= 1'b0;
        while (pending_out.size() != 0)
            @(negedge clk);
        // Let the sequencer settle after items that produce nothing
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_station_addr(input logic [7:0] a);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mfr_pkg::ADDR_MY_ADDRESS;
        pwdata  <= {24'd0, a};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        station_addr = a;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Fill frame_body with n bytes, the last one a line feed
    task automatic build_body(input int n, input bit allow_zero);
        logic [7:0] b;
        frame_body.delete();
        for (int i = 0; i < n - 1; i++)
        begin
            b = allow_zero ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 255));
            if (b == mfr_pkg::LINE_FEED)
                b = 8'h0B;
            frame_body.push_back(b);
        end
        if (allow_zero && n > 1 && $urandom_range(0, 3) == 0)
            frame_body[$urandom_range(0, n - 2)] = 8'h00;
        frame_body.push_back(mfr_pkg::LINE_FEED);
    endtask

    // data_flag: 0 ninth bit clear on data, 1 set, 2 random
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] check_flip,
                              input int data_flag);
        logic [7:0] sum;
        logic       nb;
        sum = addr;
        send_item(addr, 1'b1);
        foreach (frame_body[i])
        begin
            sum = sum + frame_body[i];
            nb  = (data_flag == 2) ? 1'($urandom_range(0, 1)) : (data_flag == 1);
            send_item(frame_body[i], nb);
        end
        send_item((sum & mfr_pkg::SUM_MASK) ^ check_flip, 1'($urandom_range(0, 1)));
    endtask

    // Bring the predicted phase back to idle before a register write
    task automatic close_open_frame;
        if (fr_phase == TAKE_DATA)
            send_item(mfr_pkg::LINE_FEED, 1'b0);
        if (fr_phase == TAKE_CHECK)
            send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_directed;
        wait_results_done();
        write_station_addr(8'h55);
        send_item(8'h55, 1'b0);               // data byte while idle
        send_item(8'h54, 1'b1);               // address of another station
        frame_body = '{8'hFF, mfr_pkg::LINE_FEED};
        send_frame(8'h55, 8'h00, 1);          // ninth bit set on data bytes
        frame_body = '{mfr_pkg::LINE_FEED};
        send_frame(8'h55, 8'h04, 0);          // wrong check byte
        frame_body = '{8'h00, 8'h5A, mfr_pkg::LINE_FEED};
        send_frame(8'h55, 8'h00, 0);          // zero first: reply only
        frame_body = '{mfr_pkg::LINE_FEED};
        send_frame(8'h55, 8'h80, 0);          // check byte with top bit set
        frame_body = '{8'h01, 8'h80, mfr_pkg::LINE_FEED};
        send_frame(8'h55, 8'h00, 0);
    endtask

    task automatic test_store_full;
        wait_results_done();
        write_station_addr(8'hA3);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        build_body(CMD_DEPTH + 9, 1'b0);      // overflow bytes summed, not stored
        send_frame(8'hA3, 8'h00, 0);
        build_body(CMD_DEPTH, 1'b0);          // line feed in the last slot
        send_frame(8'hA3, 8'h00, 0);
        build_body(CMD_DEPTH + 1, 1'b0);      // line feed dropped past the end
        send_frame(8'hA3, 8'h00, 2);
        build_body(CMD_DEPTH + 3, 1'b0);
        send_frame(8'hA3, 8'h02, 0);
    endtask

    task automatic test_backpressure;
        wait_results_done();
        src_gaps  = 1'b0;
        sink_gaps = 1'b1;
        hold_req  = LONG_HOLD;
        // Keep offering frames while the output side is held off
        repeat (4)
        begin
            build_body(6, 1'b0);
            send_frame(station_addr, 8'h00, 0);
        end
        // Pause until everything is out, then go again
        wait_results_done();
        src_gaps = 1'b1;
        build_body(5, 1'b0);
        send_frame(station_addr, 8'h00, 0);
    endtask

    task automatic test_random_traffic;
        int         phase_no;
        int         phase_end;
        int         stop_at;
        int         pick;
        int         n;
        logic [7:0] a;
        logic [7:0] flip;
        phase_no = 0;
        stop_at  = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            close_open_frame();
            wait_results_done();
            case (phase_no)
                0:       a = 8'h00;
                1:       a = 8'hFF;
                default: a = 8'($urandom_range(0, 255));
            endcase
            write_station_addr(a);
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            phase_end = items_sent + 40 + $urandom_range(0, 30);
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 19);
                n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, CMD_DEPTH + 8)
                                                   : $urandom_range(1, 8);
                build_body(n, 1'b1);
                flip = ($urandom_range(0, 3) != 0) ? 8'h00
                                                   : 8'(8'h01 << $urandom_range(0, 7));
                if (pick < 14)
                begin
                    send_frame(station_addr, flip, $urandom_range(0, 1) ? 2 : 0);
                end
                else if (pick < 16)
                begin
                    send_frame(station_addr + 8'($urandom_range(1, 255)), 8'h00, 0);
                end
                else if (pick < 18)
                begin
                    // Cut short: address and one to three random bytes instead of a full frame
                    send_item(station_addr, 1'b1);
                    repeat ($urandom_range(1, 3))
                        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
            phase_no++;
        end
        close_open_frame();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_store_full();
        test_backpressure();
        test_random_traffic();
        wait_results_done();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d items still expected", pending_out.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
